>>> hdl/jst_pkg.sv
// Shared types and constants for the job slot table.
// Holds table sizing, action and status codes, the controller state type
// and the command and status words between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package jst_pkg;

	// Table sizing.
	localparam int TABLE_DEPTH = 16;
	localparam int PID_WIDTH   = 22;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int JOB_W       = $clog2(TABLE_DEPTH + 1);
	localparam int STATE_W     = 2;
	localparam int ACT_W       = 3;
	localparam int STATUS_W    = 2;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_FIND_PID = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FIND_JOB = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIND_FG  = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	// Reset value of the foreground code register.
	localparam logic [STATE_W-1:0] FG_CODE_RESET = 2'd1;

	// Controller states.
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SCAN,
		CS_FINISH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic step;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/jst_ctrl.sv
// Controller state machine for the job slot table.
// Depends on jst_pkg; drives the datapath through ctl_cmd_t commands.
`timescale 1ns / 1ps
`default_nettype none

module jst_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  jst_pkg::dp_stat_t  stat,
	output jst_pkg::ctl_cmd_t  cmd,
	output logic               busy
);
	import jst_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.step    = 1'b0;
		cmd.finish  = 1'b0;
		busy        = 1'b1;
		unique case (state_q)
			CS_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = stat.skip ? CS_FINISH : CS_SCAN;
				end
			end
			CS_SCAN: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = CS_FINISH;
				end
			end
			CS_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/jst_datapath.sv
// Datapath of the job slot table: slot storage, scan pointer, match and
// maximum logic, next job number and the result registers.
// Depends on jst_pkg; obeys ctl_cmd_t commands from jst_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module jst_datapath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  jst_pkg::ctl_cmd_t                    cmd,
	output jst_pkg::dp_stat_t                    stat,
	input  wire  [jst_pkg::ACT_W-1:0]            action,
	input  wire  [jst_pkg::PID_WIDTH-1:0]        proc_id,
	input  wire  [jst_pkg::JOB_W-1:0]            job_number,
	input  wire  [jst_pkg::STATE_W-1:0]          run_state,
	input  wire                                  cfg_we,
	input  wire  [jst_pkg::STATE_W-1:0]          cfg_data,
	output logic                                 done,
	output logic [jst_pkg::STATUS_W-1:0]         status,
	output logic [jst_pkg::PID_WIDTH-1:0]        found_pid,
	output logic [jst_pkg::JOB_W-1:0]            found_job,
	output logic [jst_pkg::STATE_W-1:0]          found_state,
	output logic [jst_pkg::SLOT_W-1:0]           found_slot
);
	import jst_pkg::*;

	// Slot storage, cleared by reset.
	logic [PID_WIDTH-1:0] pid_tbl_q [TABLE_DEPTH];
	logic [JOB_W-1:0]     job_tbl_q [TABLE_DEPTH];
	logic [STATE_W-1:0]   st_tbl_q  [TABLE_DEPTH];

	logic [JOB_W-1:0]     next_job_q;
	logic [STATE_W-1:0]   fg_code_q;

	// Captured request.
	logic [ACT_W-1:0]     act_q;
	logic [PID_WIDTH-1:0] pid_q;
	logic [JOB_W-1:0]     job_q;
	logic [STATE_W-1:0]   rs_q;
	logic                 invalid_q;

	// Scan state.
	logic [SLOT_W-1:0]    idx_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    hit_slot_q;
	logic [PID_WIDTH-1:0] hit_pid_q;
	logic [JOB_W-1:0]     hit_job_q;
	logic [STATE_W-1:0]   hit_st_q;
	logic [JOB_W-1:0]     max_q;

	// Result registers.
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [PID_WIDTH-1:0] res_pid_q;
	logic [JOB_W-1:0]     res_job_q;
	logic [STATE_W-1:0]   res_st_q;
	logic [SLOT_W-1:0]    res_slot_q;

	logic                 in_invalid;
	logic                 in_unused;
	logic [PID_WIDTH-1:0] ent_pid;
	logic [JOB_W-1:0]     ent_job;
	logic [STATE_W-1:0]   ent_st;
	logic                 ent_match;
	logic                 first_hit;
	logic [JOB_W:0]       max_inc;
	logic [JOB_W-1:0]     next_after_del;
	logic [JOB_W-1:0]     next_after_add;
	logic                 is_unused_q;
	logic                 add_ok;
	logic                 del_ok;

	// Checks on the incoming word, used to skip the scan.
	always_comb begin
		in_invalid = 1'b0;
		in_unused  = 1'b0;
		case (action)
			ACT_ADD, ACT_DELETE, ACT_FIND_PID: in_invalid = (proc_id == '0);
			ACT_FIND_JOB:                      in_invalid = (job_number == '0);
			ACT_FIND_FG:                       in_invalid = 1'b0;
			default:                           in_unused  = 1'b1;
		endcase
	end

	assign stat.skip = in_invalid | in_unused;
	assign stat.last = (idx_q == SLOT_W'(TABLE_DEPTH - 1));

	// Entry under the scan pointer and its match for the current action.
	assign ent_pid = pid_tbl_q[idx_q];
	assign ent_job = job_tbl_q[idx_q];
	assign ent_st  = st_tbl_q[idx_q];

	always_comb begin
		case (act_q)
			ACT_ADD:                  ent_match = (ent_pid == '0);
			ACT_DELETE, ACT_FIND_PID: ent_match = (ent_pid == pid_q);
			ACT_FIND_JOB:             ent_match = (ent_job == job_q);
			ACT_FIND_FG:              ent_match = (ent_pid != '0) && (ent_st == fg_code_q);
			default:                  ent_match = 1'b0;
		endcase
	end

	assign first_hit = ent_match & ~hit_q;

	// Next job number after an add or a delete, wrapping to one when it would pass the depth.
	assign next_after_add = (next_job_q == JOB_W'(TABLE_DEPTH)) ? JOB_W'(1)
		: next_job_q + JOB_W'(1);
	assign max_inc        = {1'b0, max_q} + (JOB_W + 1)'(1);
	assign next_after_del = (max_inc > (JOB_W + 1)'(TABLE_DEPTH)) ? JOB_W'(1)
		: max_inc[JOB_W-1:0];

	assign is_unused_q = (act_q != ACT_ADD) && (act_q != ACT_DELETE)
		&& (act_q != ACT_FIND_PID) && (act_q != ACT_FIND_JOB) && (act_q != ACT_FIND_FG);
	assign add_ok = ~invalid_q & (act_q == ACT_ADD) & hit_q;
	assign del_ok = ~invalid_q & (act_q == ACT_DELETE) & hit_q;

	// Captured request words.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q     <= action;
			pid_q     <= proc_id;
			job_q     <= job_number;
			rs_q      <= run_state;
			invalid_q <= in_invalid;
		end
	end

	// Scan pointer, first match and the largest job number outside the match.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			max_q <= '0;
		end else if (cmd.capture) begin
			idx_q <= '0;
			hit_q <= 1'b0;
			max_q <= '0;
		end else if (cmd.step) begin
			idx_q <= idx_q + SLOT_W'(1);
			if (first_hit) begin
				hit_q <= 1'b1;
			end else if (ent_job > max_q) begin
				max_q <= ent_job;
			end
		end
	end

	// Copy of the first matching entry.
	always_ff @(posedge clk) begin
		if (cmd.step && first_hit) begin
			hit_slot_q <= idx_q;
			hit_pid_q  <= ent_pid;
			hit_job_q  <= ent_job;
			hit_st_q   <= ent_st;
		end
	end

	// Slot storage updates and the next job number.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				pid_tbl_q[i] <= '0;
				job_tbl_q[i] <= '0;
				st_tbl_q[i]  <= '0;
			end
			next_job_q <= JOB_W'(1);
		end else if (cmd.finish) begin
			if (add_ok) begin
				pid_tbl_q[hit_slot_q] <= pid_q;
				job_tbl_q[hit_slot_q] <= next_job_q;
				st_tbl_q[hit_slot_q]  <= rs_q;
				next_job_q            <= next_after_add;
			end else if (del_ok) begin
				pid_tbl_q[hit_slot_q] <= '0;
				job_tbl_q[hit_slot_q] <= '0;
				st_tbl_q[hit_slot_q]  <= '0;
				next_job_q            <= next_after_del;
			end
		end
	end

	// Foreground code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_code_q <= FG_CODE_RESET;
		end else if (cfg_we) begin
			fg_code_q <= cfg_data;
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// Result word: fields are zero unless the status is ok with an entry.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_pid_q  <= '0;
			res_job_q  <= '0;
			res_st_q   <= '0;
			res_slot_q <= '0;
			if (invalid_q) begin
				status_q <= ST_INVALID;
			end else if (is_unused_q) begin
				status_q <= ST_OK;
			end else if (!hit_q) begin
				status_q <= (act_q == ACT_ADD) ? ST_FULL : ST_NOTFOUND;
			end else begin
				status_q   <= ST_OK;
				res_slot_q <= hit_slot_q;
				if (act_q == ACT_ADD) begin
					res_pid_q <= pid_q;
					res_job_q <= next_job_q;
					res_st_q  <= rs_q;
				end else begin
					res_pid_q <= hit_pid_q;
					res_job_q <= hit_job_q;
					res_st_q  <= hit_st_q;
				end
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_pid   = res_pid_q;
	assign found_job   = res_job_q;
	assign found_state = res_st_q;
	assign found_slot  = res_slot_q;

endmodule

`default_nettype wire

>>> hdl/job_slot_table_unit.sv
// Top level of the job slot table: controller plus datapath.
// Depends on jst_pkg, jst_ctrl and jst_datapath.
//
// A request word is taken when start is high and busy is low. Add, delete
// and the three finds walk the slots one per cycle in the scan state, then
// pass the finish state, which registers the result; a rejected id or an
// unused action code skips the walk and goes straight to the finish state.
// The result is shown for exactly one cycle with done high and cannot be
// held off, so capture it in that cycle. Busy is low again in the result
// cycle, and a new request may be taken there.
// The foreground code is written through cfg_valid/cfg_ready while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module job_slot_table_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [jst_pkg::ACT_W-1:0]            action,
	input  wire  [jst_pkg::PID_WIDTH-1:0]        proc_id,
	input  wire  [jst_pkg::JOB_W-1:0]            job_number,
	input  wire  [jst_pkg::STATE_W-1:0]          run_state,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [jst_pkg::STATE_W-1:0]          cfg_data,
	output logic                                 done,
	output logic [jst_pkg::STATUS_W-1:0]         status,
	output logic [jst_pkg::PID_WIDTH-1:0]        found_pid,
	output logic [jst_pkg::JOB_W-1:0]            found_job,
	output logic [jst_pkg::STATE_W-1:0]          found_state,
	output logic [jst_pkg::SLOT_W-1:0]           found_slot
);
	import jst_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Configuration words are taken whenever no request is in flight.
	assign cfg_ready = ~busy;

	jst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	jst_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.proc_id     (proc_id),
		.job_number  (job_number),
		.run_state   (run_state),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.found_pid   (found_pid),
		.found_job   (found_job),
		.found_state (found_state),
		.found_slot  (found_slot)
	);

endmodule

`default_nettype wire

>>> hdl/jst_checker.sv
// Port-level checks for job_slot_table_unit, attached with a bind.
// Depends on jst_pkg for field widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module jst_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire [jst_pkg::STATUS_W-1:0]   status,
	input wire [jst_pkg::PID_WIDTH-1:0]  found_pid,
	input wire [jst_pkg::JOB_W-1:0]      found_job,
	input wire [jst_pkg::STATE_W-1:0]    found_state,
	input wire [jst_pkg::SLOT_W-1:0]     found_slot
);
	import jst_pkg::*;

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted request");

	// A result word lasts one cycle only.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// The result appears exactly when busy drops.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A result never shows up while a request is still in work.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A failing status carries no entry.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> (found_pid == '0) && (found_job == '0)
			&& (found_state == '0) && (found_slot == '0))
		else $error("entry fields not zero on a failing status");

endmodule

bind job_slot_table_unit jst_checker u_jst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.found_pid   (found_pid),
	.found_job   (found_job),
	.found_state (found_state),
	.found_slot  (found_slot)
);

`default_nettype wire
